// ===== design/assert_macros.svh =====
// Assertion helpers for the checker in mer_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mer_pkg.sv =====
`default_nettype none

package mer_pkg;

    typedef struct packed {
        logic               raw_cmd;
        logic signed [15:0] raw_target;
    } in_item_t;

    typedef struct packed {
        logic       steady_cmd;
        logic [7:0] smoothed_target;
        logic [7:0] ramped_value;
        logic       overload;
    } out_item_t;

    typedef struct packed {
        logic [3:0] debounce_ticks;
        logic [7:0] slew_step;
        logic [7:0] overload_level;
    } cfg_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 2'd0,
        CFG_SLEW_STEP      = 2'd1,
        CFG_OVERLOAD_LEVEL = 2'd2
    } cfg_index_t;

    localparam logic [3:0] DEBOUNCE_TICKS_RST = 4'd2;
    localparam logic [7:0] SLEW_STEP_RST      = 8'd5;
    localparam logic [7:0] OVERLOAD_LEVEL_RST = 8'd230;

    localparam logic [7:0] SAMPLE_MAX = 8'd255;

    // Smoother weights: 3/10 on the new median, 7/10 on the previous output.
    localparam logic [3:0] EMA_NEW_WEIGHT = 4'd3;
    localparam logic [3:0] EMA_OLD_WEIGHT = 4'd7;

    // floor(x / 10) == (x * 1639) >> 14, exact for x up to 10 * 255.
    localparam logic [10:0] DIV10_RECIP = 11'd1639;
    localparam int          DIV10_SHIFT = 14;

endpackage

`default_nettype wire

// ===== design/median_ema_ramp_conditioner.sv =====
// Median / EMA / slew conditioner for one control tick per transfer.
//
// Input channel (in_valid, in_stall, in_data): one transfer per tick, carrying
// a raw command bit and a signed raw target. Output channel (out_valid,
// out_stall, out_data): exactly one result per input transfer, in order.
// Configuration (cfg_we, cfg_index, cfg_data): write debounce_ticks, the slew
// step or overload_level while the block is idle; other indexes are dropped.
//
// Path: an input transfer is held in the input register, then in the result
// register, before it shows on out_data.
// Throughput: one transfer per cycle while out_stall stays low; all state
// updates for an item happen as it moves from the input to the result register.
//
// Reset: clears the debounce state, the sample window, the smoother and the
// ramp to zero, and loads the register defaults (2, 5, 230).
// Stall: a stalled result holds; the input register keeps filling, and
// in_stall rises only while the result is stalled and the input register is full.
`default_nettype none

module median_ema_ramp_conditioner #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire mer_pkg::in_item_t                   in_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mer_pkg::out_item_t                       out_data,
    input  wire logic                                cfg_we,
    input  wire logic [mer_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [mer_pkg::CFG_DATA_W-1:0]      cfg_data
);

    mer_pkg::cfg_t      cfg_reg;
    mer_pkg::in_item_t  s1_data_reg;
    logic               s1_valid_reg;
    mer_pkg::out_item_t out_data_reg;
    mer_pkg::out_item_t out_data_next;
    logic               out_valid_reg;
    logic               advance;
    logic               step;
    logic               in_take;
    logic               steady_cmd;
    logic [7:0]         median;
    logic [7:0]         smoothed;
    logic [7:0]         ramped;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= mer_pkg::DEBOUNCE_TICKS_RST;
            cfg_reg.slew_step      <= mer_pkg::SLEW_STEP_RST;
            cfg_reg.overload_level <= mer_pkg::OVERLOAD_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (mer_pkg::cfg_index_t'(cfg_index))
                mer_pkg::CFG_DEBOUNCE_TICKS: cfg_reg.debounce_ticks <= cfg_data[3:0];
                mer_pkg::CFG_SLEW_STEP:      cfg_reg.slew_step      <= cfg_data[7:0];
                mer_pkg::CFG_OVERLOAD_LEVEL: cfg_reg.overload_level <= cfg_data[7:0];
                default:                     ;
            endcase
        end
    end

    // Result register moves when empty or taken; the input register moves with it or when empty.
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!s1_valid_reg || advance)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_data_reg <= in_data;
    end

    mer_debounce u_debounce (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .raw_cmd    (s1_data_reg.raw_cmd),
        .cfg        (cfg_reg),
        .steady_cmd (steady_cmd)
    );

    mer_median #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .raw_target (s1_data_reg.raw_target),
        .median     (median)
    );

    mer_smooth u_smooth (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .median   (median),
        .cfg      (cfg_reg),
        .smoothed (smoothed),
        .ramped   (ramped)
    );

    always_comb
    begin
        out_data_next.steady_cmd      = steady_cmd;
        out_data_next.smoothed_target = smoothed;
        out_data_next.ramped_value    = ramped;
        out_data_next.overload        = (ramped > cfg_reg.overload_level);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== design/mer_debounce.sv =====
`default_nettype none

module mer_debounce (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic          raw_cmd,
    input  wire mer_pkg::cfg_t cfg,
    output logic               steady_cmd
);

    logic       last_seen_reg;
    logic       last_seen_next;
    logic [3:0] count_reg;
    logic [3:0] count_next;
    logic       accepted_reg;
    logic       accepted_next;
    logic [3:0] count_inc;

    assign count_inc = count_reg + 4'd1;

    always_comb
    begin
        last_seen_next = last_seen_reg;
        count_next     = count_reg;
        accepted_next  = accepted_reg;
        if (raw_cmd != accepted_reg)
        begin
            if (raw_cmd == last_seen_reg)
            begin
                count_next = count_inc;
                if (count_inc >= cfg.debounce_ticks)
                begin
                    accepted_next = raw_cmd;
                    count_next    = 4'd0;
                end
            end
            else
            begin
                // restart the run on a fresh edge
                count_next     = 4'd1;
                last_seen_next = raw_cmd;
            end
        end
        else
        begin
            count_next     = 4'd0;
            last_seen_next = raw_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_seen_reg <= 1'b0;
            count_reg     <= 4'd0;
            accepted_reg  <= 1'b0;
        end
        else if (step)
        begin
            last_seen_reg <= last_seen_next;
            count_reg     <= count_next;
            accepted_reg  <= accepted_next;
        end
    end

    assign steady_cmd = accepted_next;

endmodule

`default_nettype wire

// ===== design/mer_median.sv =====
`default_nettype none

module mer_median #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic signed [15:0] raw_target,
    output logic [7:0]              median
);

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int MID   = WINDOW_LEN / 2;
    localparam int LAST  = WINDOW_LEN - 1;

    logic [7:0]       win_reg  [WINDOW_LEN];
    logic [7:0]       win_next [WINDOW_LEN];
    logic [POS_W-1:0] rank     [WINDOW_LEN];
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [7:0]       sample;

    // Clamp to 0..255: negative goes to zero, anything above a byte saturates.
    always_comb
    begin
        if (raw_target[15])
            sample = 8'd0;
        else if (|raw_target[14:8])
            sample = mer_pkg::SAMPLE_MAX;
        else
            sample = raw_target[7:0];
    end

    assign pos_next = (pos_reg == POS_W'(LAST)) ? '0 : pos_reg + POS_W'(1);

    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
            win_next[i] = (pos_reg == POS_W'(i)) ? sample : win_reg[i];
    end

    // Stable rank of each entry; ties break by slot order so ranks are unique.
    always_comb
    begin
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            rank[i] = '0;
            for (int j = 0; j < WINDOW_LEN; j++)
            begin
                if (j != i)
                begin
                    if ((win_next[j] < win_next[i]) ||
                        ((win_next[j] == win_next[i]) && (j < i)))
                        rank[i] = rank[i] + POS_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        median = 8'd0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            if (rank[i] == POS_W'(MID))
                median = win_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < WINDOW_LEN; i++)
                win_reg[i] <= 8'd0;
        end
        else if (step)
        begin
            pos_reg <= pos_next;
            for (int i = 0; i < WINDOW_LEN; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule

`default_nettype wire

// ===== design/mer_smooth.sv =====
`default_nettype none

module mer_smooth (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    median,
    input  wire mer_pkg::cfg_t cfg,
    output logic [7:0]         smoothed,
    output logic [7:0]         ramped
);

    logic [7:0]  prev_reg;
    logic [7:0]  ramp_reg;
    logic [11:0] weighted;
    logic [21:0] product;
    logic [7:0]  ramp_next;

    assign weighted = {4'b0, median}   * 12'(mer_pkg::EMA_NEW_WEIGHT)
                    + {4'b0, prev_reg} * 12'(mer_pkg::EMA_OLD_WEIGHT);

    // Divide by ten through the reciprocal multiply.
    assign product  = {10'b0, weighted} * 22'(mer_pkg::DIV10_RECIP);
    assign smoothed = product[mer_pkg::DIV10_SHIFT +: 8];

    always_comb
    begin
        if ((smoothed > ramp_reg) && ((smoothed - ramp_reg) > cfg.slew_step))
            ramp_next = ramp_reg + cfg.slew_step;
        else if ((ramp_reg > smoothed) && ((ramp_reg - smoothed) > cfg.slew_step))
            ramp_next = ramp_reg - cfg.slew_step;
        else
            ramp_next = smoothed;
    end

    assign ramped = ramp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= 8'd0;
            ramp_reg <= 8'd0;
        end
        else if (step)
        begin
            prev_reg <= smoothed;
            ramp_reg <= ramp_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/mer_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module mer_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire mer_pkg::out_item_t out_data
);

    // A stalled result stays put.
    `MER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

    // A result leaves only through a transfer.
    `MER_ASSERT_NOW(a_out_no_drop, clk, rst_n, $fell(out_valid), $past(!out_stall), "result dropped without transfer")

    // Input back-pressure only comes from a blocked result.
    `MER_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled while output free")

    // A new result after an empty output comes from an input transfer through the input register.
    `MER_ASSERT_NOW(a_out_source, clk, rst_n, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without input transfer")

endmodule

bind median_ema_ramp_conditioner mer_checker u_mer_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

`default_nettype wire

// ===== tb/conditioner_checker.sv =====
`default_nettype none

module conditioner_checker #(
    parameter int WINDOW_LEN = 5
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  wire mer_pkg::in_item_t               in_data,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire mer_pkg::out_item_t              out_data,
    input  wire logic                            cfg_we,
    input  wire logic [mer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mer_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                   mismatches,
    output int                                   outstanding,
    output int                                   compared
);

    // register copies
    logic [3:0] debounce_need;
    logic [7:0] slew_limit;
    logic [7:0] overload_limit;

    // conditioner state
    logic       cmd_candidate;
    logic [3:0] candidate_run;
    logic       cmd_held;
    logic [7:0] window [WINDOW_LEN];
    int         window_slot;
    logic [7:0] smooth_prev;
    logic [7:0] ramp_level;

    mer_pkg::out_item_t pending_results [$];

    function automatic mer_pkg::out_item_t condition_tick(input mer_pkg::in_item_t item);
        mer_pkg::out_item_t res;
        logic [7:0]         sample;
        logic [7:0]         sorted [WINDOW_LEN];
        logic [7:0]         v;
        int                 i;
        int                 k;
        int unsigned        smooth;
        // debounce: a differing bit must repeat before it is taken over
        if (item.raw_cmd != cmd_held) begin
            if (item.raw_cmd == cmd_candidate) begin
                candidate_run = candidate_run + 4'd1;
                if (candidate_run >= debounce_need) begin
                    cmd_held      = item.raw_cmd;
                    candidate_run = '0;
                end
            end
            else begin
                candidate_run = 4'd1;
                cmd_candidate = item.raw_cmd;
            end
        end
        else begin
            candidate_run = '0;
            cmd_candidate = item.raw_cmd;
        end

        if (item.raw_target[15])
            sample = '0;
        else if (item.raw_target[14:8] != '0)
            sample = mer_pkg::SAMPLE_MAX;
        else
            sample = item.raw_target[7:0];

        window[window_slot] = sample;
        window_slot = (window_slot == WINDOW_LEN - 1) ? 0 : window_slot + 1;

        sorted = window;
        for (i = 1; i < WINDOW_LEN; i++) begin
            v = sorted[i];
            k = i;
            while (k > 0 && sorted[k-1] > v) begin
                sorted[k] = sorted[k-1];
                k--;
            end
            sorted[k] = v;
        end

        smooth = (int'(mer_pkg::EMA_NEW_WEIGHT) * int'(sorted[WINDOW_LEN/2])
                  + int'(mer_pkg::EMA_OLD_WEIGHT) * int'(smooth_prev)) / 10;
        smooth_prev = smooth[7:0];

        if (smooth > ramp_level && smooth - ramp_level > slew_limit)
            ramp_level = ramp_level + slew_limit;
        else if (ramp_level > smooth && ramp_level - smooth > slew_limit)
            ramp_level = ramp_level - slew_limit;
        else
            ramp_level = smooth[7:0];

        res.steady_cmd      = cmd_held;
        res.smoothed_target = smooth[7:0];
        res.ramped_value    = ramp_level;
        res.overload        = ramp_level > overload_limit;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("conditioner mismatch at result %0d: %s got %0d want %0d",
                 compared, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n) begin
        mer_pkg::out_item_t want;
        if (!rst_n) begin
            debounce_need  = mer_pkg::DEBOUNCE_TICKS_RST;
            slew_limit     = mer_pkg::SLEW_STEP_RST;
            overload_limit = mer_pkg::OVERLOAD_LEVEL_RST;
            cmd_candidate  = 1'b0;
            candidate_run  = '0;
            cmd_held       = 1'b0;
            for (int i = 0; i < WINDOW_LEN; i++)
                window[i] = '0;
            window_slot    = 0;
            smooth_prev    = '0;
            ramp_level     = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    mer_pkg::CFG_DEBOUNCE_TICKS: debounce_need  = cfg_data[3:0];
                    mer_pkg::CFG_SLEW_STEP:      slew_limit     = cfg_data[7:0];
                    mer_pkg::CFG_OVERLOAD_LEVEL: overload_limit = cfg_data[7:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("unexpected result", int'(out_data), -1);
                end
                else begin
                    want = pending_results.pop_front();
                    if (out_data.steady_cmd !== want.steady_cmd)
                        flag_mismatch("steady_cmd", out_data.steady_cmd, want.steady_cmd);
                    if (out_data.smoothed_target !== want.smoothed_target)
                        flag_mismatch("smoothed_target", out_data.smoothed_target,
                                      want.smoothed_target);
                    if (out_data.ramped_value !== want.ramped_value)
                        flag_mismatch("ramped_value", out_data.ramped_value,
                                      want.ramped_value);
                    if (out_data.overload !== want.overload)
                        flag_mismatch("overload", out_data.overload, want.overload);
                    compared++;
                end
            end

            if (in_valid && !in_stall)
                pending_results.push_back(condition_tick(in_data));

            outstanding <= pending_results.size();
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

    localparam int WINDOW_LEN  = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 8;
    localparam int MAX_WAIT    = 17;
    localparam int BURST_LEN   = 65;

    // index with no register behind it; writes there must be dropped
    localparam logic [mer_pkg::CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_stall;
    mer_pkg::in_item_t               in_data   = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    mer_pkg::out_item_t              out_data;
    logic                            cfg_we    = 1'b0;
    logic [mer_pkg::CFG_INDEX_W-1:0] cfg_index = mer_pkg::CFG_DEBOUNCE_TICKS;
    logic [mer_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;
    int compared;
    int sent      = 0;
    int settings  = 1;
    int cycles;

    bit src_quiet  = 1'b0;
    bit sink_quiet = 1'b0;

    logic       cmd_level    = 1'b0;
    int         run_left     = 0;
    logic [7:0] drift_center = 8'd128;

    always #4 clk = ~clk;

    median_ema_ramp_conditioner #(.WINDOW_LEN(WINDOW_LEN)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    conditioner_checker #(.WINDOW_LEN(WINDOW_LEN)) watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    function automatic int unsigned draw_wait(input bit quiet);
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic send_sample(input logic cmd, input logic signed [15:0] target);
        int unsigned gap;
        gap = draw_wait(src_quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{raw_cmd: cmd, raw_target: target};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    // hold the input side until every result is back
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_registers(input logic [7:0] ticks, input logic [7:0] step,
                                 input logic [7:0] level);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= mer_pkg::CFG_DEBOUNCE_TICKS;
        cfg_data  <= ticks;
        @(posedge clk);
        cfg_index <= mer_pkg::CFG_SLEW_STEP;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= mer_pkg::CFG_OVERLOAD_LEVEL;
        cfg_data  <= level;
        @(posedge clk);
        cfg_index <= CFG_INDEX_SPARE;
        cfg_data  <= 8'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_burst(input int count);
        logic                cmd;
        logic signed [15:0]  target;
        int                  t;
        for (int n = 0; n < count; n++) begin
            // commands come in steady runs with the odd glitch mixed in
            if (run_left == 0) begin
                cmd_level    = ~cmd_level;
                run_left     = $urandom_range(1, 18);
                drift_center = 8'($urandom);
            end
            if ($urandom_range(0, 9) == 0) begin
                cmd = ~cmd_level;
            end
            else begin
                cmd = cmd_level;
                run_left--;
            end

            case ($urandom_range(0, 9))
                0: begin
                    case ($urandom_range(0, 5))
                        0: target = 16'sh8000;
                        1: target = -16'sd1;
                        2: target = 16'sd0;
                        3: target = 16'sd255;
                        4: target = 16'sd256;
                        default: target = 16'sh7FFF;
                    endcase
                end
                1, 2: target = 16'($urandom);
                default: begin
                    t = int'(drift_center) + int'($urandom_range(0, 40)) - 20;
                    target = t[15:0];
                end
            endcase
            send_sample(cmd, target);

            if ($urandom_range(0, 59) == 0)
                settle();
        end
    endtask

    // result side: stall for a random wait, at times none, before each transfer
    initial begin
        int unsigned hold;
        forever begin
            hold = draw_wait(sink_quiet);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial begin
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on registers: debounce edges and clamp extremes
        send_sample(1'b0, 16'sd0);
        send_sample(1'b1, 16'sh8000);
        send_sample(1'b0, -16'sd1);
        send_sample(1'b1, 16'sh7FFF);
        send_sample(1'b1, 16'sd256);
        send_sample(1'b1, 16'sd255);
        send_sample(1'b0, 16'sd1);
        send_sample(1'b1, 16'sd128);
        send_sample(1'b0, 16'sd0);
        send_sample(1'b0, 16'sh0100);
        send_sample(1'b0, 16'sd255);

        // debounce of zero (upper data bits dropped), frozen ramp, overload at zero
        set_registers(8'hF0, 8'd0, 8'd0);
        send_sample(1'b1, 16'sd0);
        send_sample(1'b1, 16'sd255);
        send_sample(1'b0, 16'sd255);
        send_sample(1'b1, 16'sd255);
        send_sample(1'b1, 16'sh5A5A);
        send_sample(1'b0, 16'sd200);

        set_registers(8'd15, 8'd1, 8'd255);
        src_quiet  = 1'b1;
        sink_quiet = 1'b1;
        random_burst(BURST_LEN);

        set_registers(8'd1, 8'd255, 8'd0);
        src_quiet  = 1'b0;
        sink_quiet = 1'b0;
        random_burst(BURST_LEN);

        repeat (4) begin
            set_registers(8'($urandom_range(1, 15)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(0, 255)));
            src_quiet  = ($urandom_range(0, 2) == 0);
            sink_quiet = ($urandom_range(0, 2) == 0);
            random_burst(BURST_LEN);
        end

        settle();
        repeat (DRAIN) @(posedge clk);

        $display("run summary: %0d samples sent, %0d results compared, %0d register settings",
                 sent, compared, settings);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire
